@@ design/dram_rank_refresh_manager_defines.svh @@
// Assertion macros shared by the refresh manager RTL.
`ifndef DRAM_RANK_REFRESH_MANAGER_DEFINES_SVH
`define DRAM_RANK_REFRESH_MANAGER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DRRM_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("refresh manager assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DRRM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("refresh manager assertion failed");

`endif

@@ design/drrm_pkg.sv @@
// Types and constants shared by the refresh manager modules.
package drrm_pkg;

	localparam int INTERVAL_W = 20;
	localparam int LIMIT_W    = 4;
	localparam int FLEX_W     = 5;

	localparam logic [INTERVAL_W-1:0] REFI_RESET          = 20'd12480;
	localparam logic [LIMIT_W-1:0]    MAX_POSTPONED_RESET = 4'd8;
	localparam logic [LIMIT_W-1:0]    MAX_PULLED_IN_RESET = 4'd8;

	localparam logic signed [FLEX_W:0] FLEX_HI = 6'sd15;
	localparam logic signed [FLEX_W:0] FLEX_LO = -6'sd16;

	typedef enum logic [1:0] {
		REG_INTERVAL      = 2'd0,
		REG_MAX_POSTPONED = 2'd1,
		REG_MAX_PULLED_IN = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		CMD_ACT    = 4'd0,
		CMD_PRE    = 4'd1,
		CMD_RDA    = 4'd2,
		CMD_WRA    = 4'd3,
		CMD_PREA   = 4'd4,
		CMD_REFA   = 4'd5,
		CMD_PDEA   = 4'd6,
		CMD_PDEP   = 4'd7,
		CMD_SREFEN = 4'd8,
		CMD_PDXA   = 4'd9,
		CMD_PDXP   = 4'd10,
		CMD_OTHER  = 4'd11
	} cmd_t;

	typedef enum logic [1:0] {
		REQ_NONE = 2'd0,
		REQ_PREA = 2'd1,
		REQ_REFA = 2'd2
	} req_t;

	typedef enum logic {
		KIND_EVAL = 1'b0,
		KIND_CMD  = 1'b1
	} kind_t;

	typedef struct packed {
		logic [INTERVAL_W-1:0] interval;
		logic [LIMIT_W-1:0]    max_postponed;
		logic [LIMIT_W-1:0]    max_pulled_in;
	} cfg_t;

	typedef struct packed {
		logic signed [FLEX_W-1:0] flex;
		logic                     pulled_in;
		logic                     asleep;
	} flags_t;

endpackage

@@ design/drrm_cfg.sv @@
// Configuration register file of the refresh manager.
module drrm_cfg import drrm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  logic [1:0] wr_index,
	input  logic [INTERVAL_W-1:0] wr_data,
	output cfg_t       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.interval      <= REFI_RESET;
			cfg_q.max_postponed <= MAX_POSTPONED_RESET;
			cfg_q.max_pulled_in <= MAX_PULLED_IN_RESET;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_INTERVAL:      cfg_q.interval      <= wr_data;
				REG_MAX_POSTPONED: cfg_q.max_postponed <= wr_data[LIMIT_W-1:0];
				REG_MAX_PULLED_IN: cfg_q.max_pulled_in <= wr_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ design/drrm_step.sv @@
// Next-state and result logic for one evaluate or command beat.
module drrm_step import drrm_pkg::*; #(
	parameter int TIME_BITS = 48,
	parameter int BANKS     = 16
) (
	input  cfg_t                         cfg,
	input  logic                         kind,
	input  logic [TIME_BITS-1:0]         now,
	input  logic                         idle,
	input  logic [3:0]                   cmd,
	input  logic [TIME_BITS-1:0]         trigger,
	input  flags_t                       flags,
	input  logic [$clog2(BANKS+1)-1:0]   open_banks,
	output logic [TIME_BITS-1:0]         trigger_nx,
	output flags_t                       flags_nx,
	output logic [$clog2(BANKS+1)-1:0]   open_banks_nx,
	output logic [1:0]                   req,
	output logic                         blk,
	output logic                         wake,
	output logic [TIME_BITS-1:0]         next_time
);

	localparam int OB_W = $clog2(BANKS+1);
	localparam logic [TIME_BITS-1:0] NEVER = {TIME_BITS{1'b1}};

	logic [TIME_BITS:0]        sum_t1, sum_t2, sum_n1, ival_x, ival2_x;
	logic [TIME_BITS-1:0]      late, late2, now_late, tr_base, tr_add;
	logic                      due, overdue, pim;
	logic signed [FLEX_W:0]    flex_x, inc_x, dec_x, maxp_x, negpull_x, after_x;
	logic signed [FLEX_W-1:0]  flex_inc, flex_dec, flex_after;

	// Saturating sums: trigger plus one and two intervals, and now plus one interval.
	assign ival_x   = (TIME_BITS+1)'(cfg.interval);
	assign ival2_x  = (TIME_BITS+1)'({cfg.interval, 1'b0});
	assign sum_t1   = {1'b0, trigger} + ival_x;
	assign sum_t2   = {1'b0, trigger} + ival2_x;
	assign sum_n1   = {1'b0, now} + ival_x;
	assign late     = sum_t1[TIME_BITS] ? NEVER : sum_t1[TIME_BITS-1:0];
	assign late2    = sum_t2[TIME_BITS] ? NEVER : sum_t2[TIME_BITS-1:0];
	assign now_late = sum_n1[TIME_BITS] ? NEVER : sum_n1[TIME_BITS-1:0];

	assign due     = (now >= trigger);
	assign overdue = (now >= late);
	assign tr_base = overdue ? late : trigger;
	assign tr_add  = overdue ? late2 : late;
	assign pim     = overdue ? 1'b0 : flags.pulled_in;

	assign flex_x    = {flags.flex[FLEX_W-1], flags.flex};
	assign inc_x     = flex_x + 6'sd1;
	assign dec_x     = flex_x - 6'sd1;
	assign flex_inc  = (inc_x > FLEX_HI) ? FLEX_HI[FLEX_W-1:0] : inc_x[FLEX_W-1:0];
	assign flex_dec  = (dec_x < FLEX_LO) ? FLEX_LO[FLEX_W-1:0] : dec_x[FLEX_W-1:0];
	assign maxp_x    = signed'({2'b00, cfg.max_postponed});
	assign negpull_x = -signed'({2'b00, cfg.max_pulled_in});
	assign flex_after = flags.pulled_in ? flex_dec : flags.flex;
	assign after_x   = {flex_after[FLEX_W-1], flex_after};

	always_comb begin
		trigger_nx    = trigger;
		flags_nx      = flags;
		open_banks_nx = open_banks;
		req           = REQ_NONE;
		blk           = 1'b0;
		wake          = 1'b0;
		next_time     = '0;
		if (kind == KIND_CMD) begin
			unique case (cmd_t'(cmd))
				CMD_ACT: begin
					if (open_banks < OB_W'(BANKS)) open_banks_nx = open_banks + OB_W'(1);
				end
				CMD_PRE, CMD_RDA, CMD_WRA: begin
					if (open_banks != '0) open_banks_nx = open_banks - OB_W'(1);
				end
				CMD_PREA: open_banks_nx = '0;
				CMD_REFA: begin
					if (flags.asleep) begin
						flags_nx.pulled_in = 1'b0;
						flags_nx.asleep    = 1'b0;
						trigger_nx         = now_late;
					end else begin
						flags_nx.flex      = flex_after;
						flags_nx.pulled_in = 1'b1;
						if (after_x == negpull_x) begin
							flags_nx.pulled_in = 1'b0;
							trigger_nx         = late;
						end
					end
				end
				CMD_PDEA, CMD_PDEP: flags_nx.asleep = 1'b1;
				CMD_SREFEN: begin
					flags_nx.asleep = 1'b1;
					trigger_nx      = NEVER;
				end
				CMD_PDXA, CMD_PDXP: flags_nx.asleep = 1'b0;
				default: ;
			endcase
		end else if (!due) begin
			next_time = trigger;
		end else begin
			wake = 1'b1;
			if (flags.asleep) begin
				next_time = NEVER;
			end else begin
				trigger_nx         = tr_base;
				flags_nx.pulled_in = pim;
				priority if (!pim && flex_x == maxp_x) begin
					// Postpone limit reached: force the refresh.
					blk       = 1'b1;
					req       = (open_banks != '0) ? REQ_PREA : REQ_REFA;
					next_time = now;
				end else if (!pim && !idle) begin
					flags_nx.flex = flex_inc;
					trigger_nx    = tr_add;
					next_time     = tr_add;
				end else if (!pim) begin
					req       = (open_banks != '0) ? REQ_PREA : REQ_REFA;
					next_time = now;
				end else if (!idle) begin
					flags_nx.pulled_in = 1'b0;
					trigger_nx         = tr_add;
					next_time          = tr_add;
				end else begin
					req       = REQ_REFA;
					next_time = now;
				end
			end
		end
	end

endmodule

@@ design/dram_rank_refresh_manager.sv @@
// A beat accepted into the input register moves through the state update logic into the
// result register, which drives the output port; one beat is accepted in every cycle while
// the output drains. The input register and the result register decouple the channels, but a
// stalled result stops the next beat from entering once the input register is occupied.
// Throughput is set by the combinational state update logic. Reset clears all control state,
// loads the configuration defaults and sets the trigger time to the default interval value 12480.
`include "dram_rank_refresh_manager_defines.svh"

module dram_rank_refresh_manager import drrm_pkg::*; #(
	parameter int BANKS     = 16,
	parameter int TIME_BITS = 48
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write channel.
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [INTERVAL_W-1:0] cfg_data,
	// Input channel.
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  kind,
	input  logic [TIME_BITS-1:0]  now_cycle,
	input  logic                  banks_all_idle,
	input  logic [3:0]            issued_command,
	// Result channel.
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            request_command,
	output logic                  block_banks,
	output logic                  wake_power_down,
	output logic [TIME_BITS-1:0]  next_check_time
);

	localparam int OB_W = $clog2(BANKS+1);

	cfg_t cfg;

	// Input register stage.
	logic                 valid_s1;
	logic                 kind_s1;
	logic [TIME_BITS-1:0] now_s1;
	logic                 idle_s1;
	logic [3:0]           cmd_s1;

	// Result register stage.
	logic                 valid_s2;
	logic [1:0]           req_s2;
	logic                 blk_s2;
	logic                 wake_s2;
	logic [TIME_BITS-1:0] next_s2;

	// Refresh state.
	logic [TIME_BITS-1:0] trigger_q;
	flags_t               flags_q;
	logic [OB_W-1:0]      open_banks_q;

	logic [TIME_BITS-1:0] trigger_nx, next_time;
	flags_t               flags_nx;
	logic [OB_W-1:0]      open_banks_nx;
	logic [1:0]           req;
	logic                 blk, wake;
	logic                 adv, in_take;

	// The configuration registers are always ready to take a write beat.
	assign cfg_ready = 1'b1;

	drrm_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// The item in the input register moves on whenever the result register is
	// empty or its beat is being taken this cycle. The state is updated at that
	// same edge, so the next item always sees the state its predecessor left.
	assign adv      = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign in_take  = in_valid && !in_stall;

	drrm_step #(
		.TIME_BITS (TIME_BITS),
		.BANKS     (BANKS)
	) u_step (
		.cfg           (cfg),
		.kind          (kind_s1),
		.now           (now_s1),
		.idle          (idle_s1),
		.cmd           (cmd_s1),
		.trigger       (trigger_q),
		.flags         (flags_q),
		.open_banks    (open_banks_q),
		.trigger_nx    (trigger_nx),
		.flags_nx      (flags_nx),
		.open_banks_nx (open_banks_nx),
		.req           (req),
		.blk           (blk),
		.wake          (wake),
		.next_time     (next_time)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			trigger_q    <= TIME_BITS'(REFI_RESET);
			flags_q      <= '0;
			open_banks_q <= '0;
		end else begin
			if (adv) begin
				valid_s1 <= in_take;
			end else if (in_take) begin
				valid_s1 <= 1'b1;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
			if (adv && valid_s1) begin
				trigger_q    <= trigger_nx;
				flags_q      <= flags_nx;
				open_banks_q <= open_banks_nx;
			end
		end
	end

	// Payload registers carry no reset; their valid bits qualify them.
	always_ff @(posedge clk) begin
		if (in_take) begin
			kind_s1 <= kind;
			now_s1  <= now_cycle;
			idle_s1 <= banks_all_idle;
			cmd_s1  <= issued_command;
		end
		if (adv && valid_s1) begin
			req_s2  <= req;
			blk_s2  <= blk;
			wake_s2 <= wake;
			next_s2 <= next_time;
		end
	end

	assign out_valid       = valid_s2;
	assign request_command = req_s2;
	assign block_banks     = blk_s2;
	assign wake_power_down = wake_s2;
	assign next_check_time = next_s2;

	// A forced refresh always comes with a wake and a command request.
	`DRRM_ASSERT_SAME(a_block_has_request, valid_s2 && blk_s2,
		wake_s2 && (req_s2 == REQ_PREA || req_s2 == REQ_REFA))
	// The open-bank count never exceeds the number of banks.
	`DRRM_ASSERT_SAME(a_open_banks_bound, 1'b1, open_banks_q <= OB_W'(BANKS))
	// The refresh state only moves when an item leaves the input register.
	`DRRM_ASSERT_NEXT(a_state_hold, !(adv && valid_s1),
		$stable(trigger_q) && $stable(flags_q) && $stable(open_banks_q))
	// Input is only held back while the input register is occupied.
	`DRRM_ASSERT_SAME(a_stall_needs_item, in_stall, valid_s1 && valid_s2 && out_stall)

endmodule

@@ test/dram_rank_refresh_manager_tb.sv @@
// Self-checking testbench for the rank refresh manager: directed and random beats scored against a predictor.
module dram_rank_refresh_manager_tb;
	import drrm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// The block is built with its default geometry; the predictor uses the same numbers.
	localparam int RANK_BANKS = 16;
	localparam int TIME_W     = 48;

	localparam logic [TIME_W-1:0] NEVER = '1;

	localparam int RESET_CYCLES   = 6;
	// Margin waited after every verdict is in, before the block counts as idle.
	localparam int DRAIN_CYCLES   = 4;
	// A correct run never goes this long without a single handshake on any channel.
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASES         = 6;
	localparam int PHASE_BEATS    = 150;
	localparam int CMD_CODE_MAX   = 15;

	// One input beat and one result beat, in the field order of the ports.
	typedef struct packed {
		kind_t             kind;
		logic [TIME_W-1:0] now;
		logic              idle;
		logic [3:0]        cmd;
	} refresh_beat_t;

	typedef struct packed {
		logic [1:0]        req;
		logic              blk;
		logic              wake;
		logic [TIME_W-1:0] next_check;
	} refresh_verdict_t;

	// Predicts the refresh schedule of one rank and holds the verdicts still owed by the block.
	class refresh_tracker;
		int unsigned       interval;
		int                postpone_limit;
		int                pull_in_limit;
		logic [TIME_W-1:0] trigger_at;
		int                flex;
		int unsigned       open_banks;
		bit                pulled_in;
		bit                asleep;
		refresh_verdict_t  awaited[$];
		int unsigned       errors;

		function new();
			interval       = REFI_RESET;
			postpone_limit = MAX_POSTPONED_RESET;
			pull_in_limit  = MAX_PULLED_IN_RESET;
			trigger_at     = TIME_W'(REFI_RESET);
			flex           = 0;
			open_banks     = 0;
			pulled_in      = 1'b0;
			asleep         = 1'b0;
			errors         = 0;
		endfunction

		function void write_register(reg_idx_t idx, logic [INTERVAL_W-1:0] data);
			case (idx)
				REG_INTERVAL:      interval = data;
				REG_MAX_POSTPONED: postpone_limit = data[LIMIT_W-1:0];
				REG_MAX_PULLED_IN: pull_in_limit = data[LIMIT_W-1:0];
				default: ;
			endcase
		endfunction

		// Time sums stick at all ones, which stands for never.
		function logic [TIME_W-1:0] sat_add(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
			logic [TIME_W:0] sum;
			sum = {1'b0, a} + {1'b0, b};
			return sum[TIME_W] ? NEVER : sum[TIME_W-1:0];
		endfunction

		function void bump_flex(int delta);
			flex += delta;
			if (flex > FLEX_HI)
				flex = FLEX_HI;
			if (flex < FLEX_LO)
				flex = FLEX_LO;
		endfunction

		function void track_command(logic [3:0] cmd, logic [TIME_W-1:0] now);
			case (cmd)
				CMD_ACT: begin
					if (open_banks < RANK_BANKS)
						open_banks++;
				end
				CMD_PRE, CMD_RDA, CMD_WRA: begin
					if (open_banks > 0)
						open_banks--;
				end
				CMD_PREA: open_banks = 0;
				CMD_REFA: begin
					if (asleep) begin
						// A refresh while asleep, as on the way out of self-refresh, restarts the schedule.
						pulled_in  = 1'b0;
						trigger_at = sat_add(now, interval);
						asleep     = 1'b0;
					end else begin
						if (pulled_in)
							bump_flex(-1);
						else
							pulled_in = 1'b1;
						if (flex == -pull_in_limit) begin
							pulled_in  = 1'b0;
							trigger_at = sat_add(trigger_at, interval);
						end
					end
				end
				CMD_PDEA, CMD_PDEP: asleep = 1'b1;
				CMD_SREFEN: begin
					asleep     = 1'b1;
					trigger_at = NEVER;
				end
				CMD_PDXA, CMD_PDXP: asleep = 1'b0;
				default: ;
			endcase
		endfunction

		// Works out the verdict for an accepted beat, queues it and hands it back.
		function refresh_verdict_t note_beat(refresh_beat_t b);
			refresh_verdict_t  v;
			logic [TIME_W-1:0] late;
			bit                issue;
			v = '0;
			if (b.kind == KIND_CMD) begin
				track_command(b.cmd, b.now);
			end else if (b.now < trigger_at) begin
				v.next_check = trigger_at;
			end else begin
				v.wake = 1'b1;
				if (asleep) begin
					v.next_check = NEVER;
				end else begin
					// A whole interval overdue: the missed refresh counts as postponed already.
					late = sat_add(trigger_at, interval);
					if (b.now >= late) begin
						trigger_at = late;
						pulled_in  = 1'b0;
					end
					if (!pulled_in) begin
						issue = 1'b1;
						if (flex == postpone_limit) begin
							v.blk = 1'b1;
						end else if (!b.idle) begin
							bump_flex(1);
							trigger_at   = sat_add(trigger_at, interval);
							v.next_check = trigger_at;
							issue        = 1'b0;
						end
						if (issue) begin
							v.req        = (open_banks > 0) ? REQ_PREA : REQ_REFA;
							v.next_check = b.now;
						end
					end else if (!b.idle) begin
						pulled_in    = 1'b0;
						trigger_at   = sat_add(trigger_at, interval);
						v.next_check = trigger_at;
					end else begin
						v.req        = REQ_REFA;
						v.next_check = b.now;
					end
				end
			end
			awaited.push_back(v);
			return v;
		endfunction

		function void complain(string what, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
			errors++;
			if (errors <= 10)
				$display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
		endfunction

		function void check_verdict(refresh_verdict_t got);
			refresh_verdict_t want;
			if (awaited.size() == 0) begin
				complain("result beat with nothing outstanding", '0, got.next_check);
				return;
			end
			want = awaited.pop_front();
			if (got.req !== want.req)
				complain("request_command", want.req, got.req);
			if (got.blk !== want.blk)
				complain("block_banks", want.blk, got.blk);
			if (got.wake !== want.wake)
				complain("wake_power_down", want.wake, got.wake);
			if (got.next_check !== want.next_check)
				complain("next_check_time", want.next_check, got.next_check);
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	// Every input of the block holds a known value from time zero on.
	logic                  clk             = 1'b0;
	logic                  arst_n          = 1'b0;
	logic                  cfg_valid       = 1'b0;
	logic                  cfg_ready;
	logic [1:0]            cfg_index       = '0;
	logic [INTERVAL_W-1:0] cfg_data        = '0;
	logic                  in_valid        = 1'b0;
	logic                  in_stall;
	logic                  kind            = 1'b0;
	logic [TIME_W-1:0]     now_cycle       = '0;
	logic                  banks_all_idle  = 1'b0;
	logic [3:0]            issued_command  = '0;
	logic                  out_valid;
	logic                  out_stall       = 1'b0;
	logic [1:0]            request_command;
	logic                  block_banks;
	logic                  wake_power_down;
	logic [TIME_W-1:0]     next_check_time;

	refresh_tracker   tracker = new();
	refresh_verdict_t last_verdict = '0;
	logic [TIME_W-1:0] clock_now = '0;
	int unsigned      snd_idle_pct = 31;
	int unsigned      rcv_idle_pct = 81;
	int unsigned      quiet_cycles = 0;

	dram_rank_refresh_manager #(
		.BANKS(RANK_BANKS),
		.TIME_BITS(TIME_W)
	) dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side: a beat is taken at an edge where valid is high and our stall was low. The
	// stall for the next cycle is drawn after the check, so the check sees the value at the edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_verdict({request_command, block_banks, wake_power_down, next_check_time});
		out_stall <= ($urandom_range(99) < rcv_idle_pct);
	end

	// Any handshake on any channel counts as progress; a long quiet stretch means a hang.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("dram_rank_refresh_manager_tb: done, errors");
			$finish;
		end
	end

	function automatic refresh_beat_t eval_beat(input logic [TIME_W-1:0] at, input logic idle);
		refresh_beat_t b;
		b.kind = KIND_EVAL;
		b.now  = at;
		b.idle = idle;
		b.cmd  = CMD_OTHER;
		return b;
	endfunction

	function automatic refresh_beat_t cmd_beat(input logic [3:0] code, input logic [TIME_W-1:0] at);
		refresh_beat_t b;
		b.kind = KIND_CMD;
		b.now  = at;
		b.idle = 1'($urandom_range(1));
		b.cmd  = code;
		return b;
	endfunction

	// A rough mix of what a rank sees: mostly activates and closes, some refresh and power
	// traffic, rare self-refresh, and the unused codes now and then.
	function automatic logic [3:0] pick_command();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 30)
			return CMD_ACT;
		if (r < 40)
			return CMD_PRE;
		if (r < 47)
			return CMD_RDA;
		if (r < 54)
			return CMD_WRA;
		if (r < 60)
			return CMD_PREA;
		if (r < 70)
			return CMD_REFA;
		if (r < 75)
			return $urandom_range(1) ? CMD_PDEA : CMD_PDEP;
		if (r < 86)
			return $urandom_range(1) ? CMD_PDXA : CMD_PDXP;
		if (r < 88)
			return CMD_SREFEN;
		return 4'($urandom_range(CMD_CODE_MAX, int'(CMD_OTHER)));
	endfunction

	// Presents one beat after a random number of idle cycles and holds it until it is taken.
	// When no gap is drawn, valid simply stays high into the next beat.
	task automatic send_beat(input refresh_beat_t b);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		kind           <= b.kind;
		now_cycle      <= b.now;
		banks_all_idle <= b.idle;
		issued_command <= b.cmd;
		do
			@(posedge clk);
		while (in_stall);
		last_verdict = tracker.note_beat(b);
	endtask

	// Registers change only on an idle block: every verdict is in and the pipe has emptied.
	task automatic wait_for_drain();
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// The limit registers take only the low bits, so the rest of the word carries junk.
	task automatic write_config(input logic [INTERVAL_W-1:0] interval,
			input logic [LIMIT_W-1:0] postponed, input logic [LIMIT_W-1:0] pulled);
		reg_idx_t              idx;
		logic [INTERVAL_W-1:0] data;
		for (int r = 0; r < 3; r++) begin
			idx = reg_idx_t'(r);
			case (idx)
				REG_INTERVAL:      data = interval;
				REG_MAX_POSTPONED: data = {16'($urandom()), postponed};
				default:           data = {16'($urandom()), pulled};
			endcase
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= data;
			do
				@(posedge clk);
			while (!cfg_ready);
			tracker.write_register(idx, data);
		end
		cfg_valid <= 1'b0;
	endtask

	// Random traffic that behaves like a memory controller most of the time. Time moves forward
	// in steps scaled to the interval, so triggers fall due often. A requested PREA or REFA is
	// usually answered by that command, which drives the postpone and pull-in loops. When the
	// trigger has run far ahead (self-refresh, or a stray timestamp), the rank is put to sleep
	// and refreshed at the current time to bring the schedule back. A few beats carry a fully
	// random timestamp as noise.
	task automatic run_traffic(input int beats);
		refresh_beat_t b;
		int unsigned   roll;
		logic [63:0]   horizon;
		for (int n = 0; n < beats; n++) begin
			roll    = $urandom_range(99);
			horizon = clock_now + 24 * tracker.interval + 64;
			b       = eval_beat(clock_now, $urandom_range(99) < 70);
			// The command field is ignored on evaluate beats, so it carries random codes.
			b.cmd   = 4'($urandom_range(CMD_CODE_MAX));
			if (tracker.trigger_at > horizon && roll < 50)
				b = cmd_beat(tracker.asleep ? CMD_REFA : CMD_PDEA, clock_now);
			else if (last_verdict.req == REQ_PREA && roll < 75)
				b = cmd_beat(CMD_PREA, clock_now);
			else if (last_verdict.req == REQ_REFA && roll < 75)
				b = cmd_beat(CMD_REFA, clock_now);
			else if (roll >= 55)
				b = cmd_beat(pick_command(), clock_now);
			if ($urandom_range(99) < 5)
				b.now = TIME_W'({$urandom(), $urandom()});
			send_beat(b);
			clock_now += TIME_W'($urandom_range(tracker.interval / 3 + 1));
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset configuration (interval 12480, both limits 8).
		send_beat(eval_beat(0, 1'b1));             // not due yet: next check at the trigger
		send_beat(cmd_beat(CMD_ACT, 0));
		send_beat(cmd_beat(CMD_ACT, 0));
		send_beat(cmd_beat(CMD_PRE, 0));
		send_beat(eval_beat(12480, 1'b1));         // due with a bank open: precharge all
		send_beat(cmd_beat(CMD_RDA, 12480));
		send_beat(cmd_beat(CMD_WRA, 12480));       // open count stays at zero
		send_beat(eval_beat(12480, 1'b1));         // due with all banks closed: refresh all
		send_beat(cmd_beat(CMD_REFA, 12480));      // enters pulled-in mode
		send_beat(eval_beat(12481, 1'b1));         // still idle: pull in another one
		send_beat(cmd_beat(CMD_REFA, 12481));
		send_beat(eval_beat(12482, 1'b0));         // banks busy: back to regular mode
		send_beat(eval_beat(24960, 1'b0));         // busy when due: postponed
		send_beat(cmd_beat(CMD_PDEP, 24960));
		send_beat(eval_beat(37440, 1'b1));         // asleep when due: wake, never
		send_beat(cmd_beat(CMD_PDXA, 37440));
		send_beat(cmd_beat(CMD_PDEA, 37440));
		send_beat(cmd_beat(CMD_PDXP, 37440));
		send_beat(cmd_beat(4'(CMD_CODE_MAX), 37440));  // unused code changes nothing
		send_beat(cmd_beat(CMD_ACT, 37440));
		send_beat(cmd_beat(CMD_PREA, 37440));
		send_beat(cmd_beat(CMD_SREFEN, 37440));    // trigger goes to never
		send_beat(eval_beat(NEVER - 1, 1'b1));
		send_beat(cmd_beat(CMD_REFA, NEVER - 3));  // exit refresh: the sum saturates
		send_beat(eval_beat(NEVER, 1'b0));         // due at the top of time, postpone saturates
		// Put the schedule back near time zero for the random part.
		send_beat(cmd_beat(CMD_PDEA, 0));
		send_beat(cmd_beat(CMD_REFA, 0));
		in_valid <= 1'b0;

		// Random part. Idling goes sender-light/receiver-heavy, then the reverse, then none;
		// each phase runs under its own configuration, the register extremes among them.
		for (int p = 0; p < PHASES; p++) begin
			case (p / 2)
				0: begin
					snd_idle_pct = 31;
					rcv_idle_pct = 81;
				end
				1: begin
					snd_idle_pct = 81;
					rcv_idle_pct = 31;
				end
				default: begin
					snd_idle_pct = 0;
					rcv_idle_pct = 0;
				end
			endcase
			wait_for_drain();
			case (p)
				0: write_config(1, 0, 0);
				1: write_config(37, 8, 8);
				2: write_config(20'hFFFFF, 2, 5);
				3: write_config(9, 15, 15);
				4: write_config(INTERVAL_W'($urandom_range(64, 1)), LIMIT_W'($urandom_range(8)),
					LIMIT_W'($urandom_range(8)));
				default: write_config(20, 3, 1);
			endcase
			run_traffic(PHASE_BEATS);
		end

		wait_for_drain();
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("dram_rank_refresh_manager_tb: done, clean");
		else
			$display("dram_rank_refresh_manager_tb: done, errors");
		$finish;
	end

endmodule
